// ===== rtl/core/crc_framed_status_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Framed status receiver: assertion macros
// Shared concurrent assertion helpers for the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_STATUS_RECEIVER_DEFINES_SVH
`define CRC_FRAMED_STATUS_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cfsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed status receiver package
// Types, protocol constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package cfsr_pkg;

  typedef enum logic [1:0] {
    StIdle,
    StCrc,
    StLen,
    StData
  } cfsr_state_e;

  typedef logic [7:0] cfsr_byte_t;

  typedef struct packed {
    logic update;
    logic binary;
  } cfsr_upd_t;

  localparam cfsr_byte_t StartByte    = 8'h7B;
  localparam cfsr_byte_t CrcPoly      = 8'h07;
  localparam cfsr_byte_t CrcXorOut    = 8'h55;
  localparam cfsr_byte_t ReplyAck     = 8'hFF;
  localparam cfsr_byte_t ReplyNak     = 8'h00;
  localparam cfsr_byte_t AsciiZero    = 8'd48;
  localparam cfsr_byte_t BinaryMinLen = 8'd9;
  localparam cfsr_byte_t VersionOne   = 8'd1;
  localparam int unsigned NumFields   = 9;
  localparam int unsigned StoreBytes  = NumFields + 1;

  // MSB-first CRC-8, one byte
  function automatic cfsr_byte_t crc8_update(input cfsr_byte_t crc, input cfsr_byte_t data);
    cfsr_byte_t c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cfsr_status_unit.sv =====
// ----------------------------------------------------------------------------
// Framed status receiver: status unit
// Holds the dimmer status and loads it from the payload bytes of a good
// status frame, in binary or ASCII layout.
// ----------------------------------------------------------------------------
module cfsr_status_unit import cfsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfsr_upd_t  upd_i,
  input  cfsr_byte_t store_i  [StoreBytes],
  output cfsr_byte_t status_o [NumFields]
);

  cfsr_byte_t status_q [NumFields];
  cfsr_byte_t status_d [NumFields];

  always_comb begin
    for (int k = 0; k < NumFields; k++) begin
      status_d[k] = status_q[k];
    end
    if (upd_i.binary) begin
      for (int k = 0; k < NumFields; k++) begin
        status_d[k] = store_i[k + 1];
      end
    end else begin
      // ASCII layout: levels are kept
      status_d[0] = VersionOne;
      status_d[1] = '0;
      status_d[2] = store_i[1] - AsciiZero;
      status_d[3] = store_i[2] - AsciiZero;
      status_d[5] = store_i[4] - AsciiZero;
      status_d[6] = store_i[5] - AsciiZero;
      status_d[8] = store_i[7] - AsciiZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumFields; k++) begin
        status_q[k] <= '0;
      end
    end else if (upd_i.update) begin
      for (int k = 0; k < NumFields; k++) begin
        status_q[k] <= status_d[k];
      end
    end
  end

  assign status_o = status_q;

endmodule

// ===== rtl/core/crc_framed_status_receiver.sv =====
// ----------------------------------------------------------------------------
// Framed status receiver
// Parses start/CRC/length/payload frames from a byte stream, checks CRC-8
// and replies ACK or NAK; good status frames update the kept dimmer status.
//
//   channel  | signals                               | role
//   ---------+---------------------------------------+---------------------------
//   in       | in_valid_i, in_ready_o, rx_byte_i     | received byte, one per request
//   out      | out_valid_o, out_ready_i, reply/status| one result per frame end
//   cfg      | cfg_we_i, cfg_wdata_i                 | status command code write
//
// One byte per cycle unless stalled; a byte is parsed in the cycle it is accepted.
// A frame result is in the output register the cycle after its last byte.
// Input is taken while the output register is empty or being drained.
// Reset clears parser state, the first ten payload bytes and the status.
// ----------------------------------------------------------------------------
`include "crc_framed_status_receiver_defines.svh"

module crc_framed_status_receiver import cfsr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] reply_byte_o,
  output logic       status_updated_o,
  output logic [7:0] rev_major_o,
  output logic [7:0] rev_minor_o,
  output logic [7:0] gate_one_on_o,
  output logic [7:0] gate_one_dimming_o,
  output logic [7:0] gate_one_level_o,
  output logic [7:0] gate_two_on_o,
  output logic [7:0] gate_two_dimming_o,
  output logic [7:0] gate_two_level_o,
  output logic [7:0] channel_lock_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BUFFER_BYTES - 1);
  localparam logic [8:0] LastLen = 9'(BUFFER_BYTES - 1);

  cfsr_state_e state_q, state_d;
  cfsr_byte_t  cmd_q;
  cfsr_byte_t  exp_crc_q, exp_crc_d;
  cfsr_byte_t  frame_len_q, frame_len_d;
  logic [IdxW-1:0] byte_idx_q, byte_idx_d;
  cfsr_byte_t  crc_q, crc_d;
  cfsr_byte_t  store_q [StoreBytes];
  cfsr_byte_t  store_d [StoreBytes];
  cfsr_byte_t  status  [NumFields];
  logic        out_valid_q;
  cfsr_byte_t  reply_q, reply_d;
  logic        updated_q;

  logic        in_fire;
  logic        frame_end;
  logic        crc_good;
  logic [IdxW:0]   idx_inc;
  logic [IdxW-1:0] idx_next;
  cfsr_upd_t   upd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_inc  = {1'b0, byte_idx_q} + 1'b1;
  assign idx_next = (9'(idx_inc) > LastLen) ? LastIdx : idx_inc[IdxW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      case (state_q)
        StIdle:  if (rx_byte_i == StartByte) state_d = StCrc;
        StCrc:   state_d = StLen;
        StLen:   state_d = StData;
        StData:  if (frame_end) state_d = StIdle;
        default: state_d = StIdle;
      endcase
    end
  end

  // Datapath
  always_comb begin
    exp_crc_d   = exp_crc_q;
    frame_len_d = frame_len_q;
    byte_idx_d  = byte_idx_q;
    crc_d       = crc_q;
    frame_end   = 1'b0;
    for (int k = 0; k < StoreBytes; k++) begin
      store_d[k] = store_q[k];
    end
    if (in_fire) begin
      case (state_q)
        StIdle: begin
          if (rx_byte_i == StartByte) begin
            byte_idx_d = '0;
            crc_d      = '0;
          end
        end
        StCrc: exp_crc_d = rx_byte_i;
        StLen: begin
          frame_len_d = (9'(rx_byte_i) > LastLen) ? 8'(BUFFER_BYTES - 1) : rx_byte_i;
        end
        default: begin
          for (int k = 0; k < StoreBytes; k++) begin
            if (byte_idx_q == IdxW'(k)) store_d[k] = rx_byte_i;
          end
          if (9'(byte_idx_q) < 9'(frame_len_q)) crc_d = crc8_update(crc_q, rx_byte_i);
          byte_idx_d = idx_next;
          if (9'(idx_next) >= 9'(frame_len_q)) begin
            frame_end  = 1'b1;
            byte_idx_d = '0;
            for (int k = 0; k < StoreBytes; k++) begin
              if (idx_next == IdxW'(k)) store_d[k] = '0;
            end
          end
        end
      endcase
    end
  end

  assign crc_good   = (crc_d ^ CrcXorOut) == exp_crc_q;
  assign reply_d    = crc_good ? ReplyAck : ReplyNak;
  assign upd.update = frame_end && crc_good && (store_d[0] == cmd_q);
  assign upd.binary = frame_len_q > BinaryMinLen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      exp_crc_q   <= '0;
      frame_len_q <= '0;
      byte_idx_q  <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
      reply_q     <= ReplyNak;
      updated_q   <= 1'b0;
      for (int k = 0; k < StoreBytes; k++) begin
        store_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      exp_crc_q   <= exp_crc_d;
      frame_len_q <= frame_len_d;
      byte_idx_q  <= byte_idx_d;
      crc_q       <= crc_d;
      for (int k = 0; k < StoreBytes; k++) begin
        store_q[k] <= store_d[k];
      end
      if (cfg_we_i) begin
        cmd_q <= cfg_wdata_i;
      end
      if (frame_end) begin
        out_valid_q <= 1'b1;
        reply_q     <= reply_d;
        updated_q   <= upd.update;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  cfsr_status_unit u_status (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .store_i  (store_d),
    .status_o (status)
  );

  assign out_valid_o        = out_valid_q;
  assign reply_byte_o       = reply_q;
  assign status_updated_o   = updated_q;
  assign rev_major_o        = status[0];
  assign rev_minor_o        = status[1];
  assign gate_one_on_o      = status[2];
  assign gate_one_dimming_o = status[3];
  assign gate_one_level_o   = status[4];
  assign gate_two_on_o      = status[5];
  assign gate_two_dimming_o = status[6];
  assign gate_two_level_o   = status[7];
  assign channel_lock_o     = status[8];

  `CFSR_ASSERT_IMPL(a_reply_code, clk_i, rst_ni, out_valid_o,
    reply_byte_o == ReplyAck || reply_byte_o == ReplyNak, "reply is neither ACK nor NAK")
  `CFSR_ASSERT_IMPL(a_update_needs_ack, clk_i, rst_ni, out_valid_o && status_updated_o,
    reply_byte_o == ReplyAck, "status updated on a bad CRC")
  `CFSR_ASSERT_IMPL(a_len_clamped, clk_i, rst_ni, state_q == StData,
    9'(frame_len_q) <= LastLen, "frame length above buffer limit")
  `CFSR_ASSERT_NEXT(a_end_to_idle, clk_i, rst_ni, frame_end,
    out_valid_o && state_q == StIdle, "frame end did not post a result")
  `CFSR_ASSERT_NEXT(a_status_hold, clk_i, rst_ni, !upd.update,
    $stable(rev_major_o) && $stable(channel_lock_o), "status moved without update")

endmodule

// ===== dv/crc_framed_status_receiver_test.sv =====
// ----------------------------------------------------------------------------
// Framed status receiver testbench
// Streams start/CRC/length/payload frames, noise and broken frames into the
// receiver with random idle bursts on both channels, predicts every reply and
// the kept dimmer status per frame, and checks each result field by field.
// ----------------------------------------------------------------------------
module crc_framed_status_receiver_test import cfsr_pkg::*;;

  localparam int unsigned BUFFER_BYTES  = 32;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldoffCycles = 400;
  localparam int unsigned PhaseBytes    = 200;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ReportLimit   = 10;

  typedef enum int unsigned {
    FldRevMajor,
    FldRevMinor,
    FldGateOneOn,
    FldGateOneDimming,
    FldGateOneLevel,
    FldGateTwoOn,
    FldGateTwoDimming,
    FldGateTwoLevel,
    FldChannelLock
  } status_field_e;

  typedef enum logic [1:0] {
    BodyAscii,
    BodyRandom,
    BodyStart
  } body_kind_e;

  typedef struct packed {
    cfsr_byte_t                   reply;
    logic                         updated;
    cfsr_byte_t [NumFields-1:0]   field;
  } frame_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] reply_byte_o;
  logic       status_updated_o;
  logic [7:0] rev_major_o;
  logic [7:0] rev_minor_o;
  logic [7:0] gate_one_on_o;
  logic [7:0] gate_one_dimming_o;
  logic [7:0] gate_one_level_o;
  logic [7:0] gate_two_on_o;
  logic [7:0] gate_two_dimming_o;
  logic [7:0] gate_two_level_o;
  logic [7:0] channel_lock_o;

  // parser copy
  cfsr_state_e parse_st    = StIdle;
  cfsr_byte_t  status_code = 8'h00;
  cfsr_byte_t  crc_rx      = 8'h00;
  cfsr_byte_t  len_clamped = 8'h00;
  cfsr_byte_t  wr_ptr      = 8'h00;
  cfsr_byte_t  crc_acc     = 8'h00;
  cfsr_byte_t  frame_buf   [BUFFER_BYTES] = '{default: 8'h00};
  cfsr_byte_t  status_kept [NumFields]    = '{default: 8'h00};

  cfsr_byte_t    request_q [$];
  frame_result_t frame_result_q [$];
  frame_result_t seen_res;
  frame_result_t due_res;

  int unsigned bytes_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned idle_pct     = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;
  logic        holdoff_go   = 1'b0;

  string field_label [NumFields] = '{
    "rev_major", "rev_minor", "gate_one_on", "gate_one_dimming",
    "gate_one_level", "gate_two_on", "gate_two_dimming", "gate_two_level",
    "channel_lock"
  };

  crc_framed_status_receiver #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reply_byte_o      (reply_byte_o),
    .status_updated_o  (status_updated_o),
    .rev_major_o       (rev_major_o),
    .rev_minor_o       (rev_minor_o),
    .gate_one_on_o     (gate_one_on_o),
    .gate_one_dimming_o(gate_one_dimming_o),
    .gate_one_level_o  (gate_one_level_o),
    .gate_two_on_o     (gate_two_on_o),
    .gate_two_dimming_o(gate_two_dimming_o),
    .gate_two_level_o  (gate_two_level_o),
    .channel_lock_o    (channel_lock_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bit-serial CRC-8, MSB first
  function automatic cfsr_byte_t crc8_step(input cfsr_byte_t acc, input cfsr_byte_t din);
    cfsr_byte_t r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ din[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  task automatic parse_rx_byte(input cfsr_byte_t b);
    int unsigned   pos;
    logic          crc_ok;
    logic          upd;
    frame_result_t res;
    case (parse_st)
      StIdle: begin
        if (b == StartByte) begin
          parse_st = StCrc;
          wr_ptr   = 8'h00;
          crc_acc  = 8'h00;
        end
      end
      StCrc: begin
        crc_rx   = b;
        parse_st = StLen;
      end
      StLen: begin
        len_clamped = (b > BUFFER_BYTES - 1) ? cfsr_byte_t'(BUFFER_BYTES - 1) : b;
        parse_st    = StData;
      end
      default: begin
        pos = (wr_ptr > BUFFER_BYTES - 1) ? BUFFER_BYTES - 1 : wr_ptr;
        frame_buf[pos] = b;
        if (pos < len_clamped) crc_acc = crc8_step(crc_acc, b);
        pos++;
        if (pos > BUFFER_BYTES - 1) pos = BUFFER_BYTES - 1;
        wr_ptr = cfsr_byte_t'(pos);
        if (pos >= len_clamped) begin
          frame_buf[pos] = 8'h00;
          parse_st       = StIdle;
          wr_ptr         = 8'h00;
          crc_ok         = ((crc_acc ^ CrcXorOut) == crc_rx);
          upd            = crc_ok && (frame_buf[0] == status_code);
          if (upd) begin
            if (len_clamped > BinaryMinLen) begin
              for (int k = 0; k < NumFields; k++) status_kept[k] = frame_buf[k + 1];
            end else begin
              status_kept[FldRevMajor]       = VersionOne;
              status_kept[FldRevMinor]       = 8'h00;
              status_kept[FldGateOneOn]      = frame_buf[1] - AsciiZero;
              status_kept[FldGateOneDimming] = frame_buf[2] - AsciiZero;
              status_kept[FldGateTwoOn]      = frame_buf[4] - AsciiZero;
              status_kept[FldGateTwoDimming] = frame_buf[5] - AsciiZero;
              status_kept[FldChannelLock]    = frame_buf[7] - AsciiZero;
            end
          end
          res.reply   = crc_ok ? ReplyAck : ReplyNak;
          res.updated = upd;
          for (int k = 0; k < NumFields; k++) res.field[k] = status_kept[k];
          frame_result_q.push_back(res);
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) parse_rx_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct) begin
          send_gap   <= $urandom_range(17);
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frame_result_q.size() == 0) begin
          flag_mismatch("result with no frame pending", 0, 32'(reply_byte_o));
        end else begin
          due_res                           = frame_result_q.pop_front();
          seen_res.reply                    = reply_byte_o;
          seen_res.updated                  = status_updated_o;
          seen_res.field[FldRevMajor]       = rev_major_o;
          seen_res.field[FldRevMinor]       = rev_minor_o;
          seen_res.field[FldGateOneOn]      = gate_one_on_o;
          seen_res.field[FldGateOneDimming] = gate_one_dimming_o;
          seen_res.field[FldGateOneLevel]   = gate_one_level_o;
          seen_res.field[FldGateTwoOn]      = gate_two_on_o;
          seen_res.field[FldGateTwoDimming] = gate_two_dimming_o;
          seen_res.field[FldGateTwoLevel]   = gate_two_level_o;
          seen_res.field[FldChannelLock]    = channel_lock_o;
          if (seen_res.reply != due_res.reply) begin
            flag_mismatch("reply_byte", 32'(due_res.reply), 32'(seen_res.reply));
          end
          if (seen_res.updated != due_res.updated) begin
            flag_mismatch("status_updated", 32'(due_res.updated), 32'(seen_res.updated));
          end
          for (int k = 0; k < NumFields; k++) begin
            if (seen_res.field[k] != due_res.field[k]) begin
              flag_mismatch(field_label[k], 32'(due_res.field[k]), 32'(seen_res.field[k]));
            end
          end
        end
      end
      if (holdoff_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        recv_stall  <= $urandom_range(17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (holdoff_go) begin
      holdoff_left <= HoldoffCycles;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input cfsr_byte_t b);
    request_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input cfsr_byte_t cmd, input cfsr_byte_t len_byte,
                             input body_kind_e kind, input bit bad_crc);
    cfsr_byte_t  body [BUFFER_BYTES];
    cfsr_byte_t  crc;
    int unsigned n_used;
    int unsigned n_sent;
    n_used = (len_byte > BUFFER_BYTES - 1) ? BUFFER_BYTES - 1 : len_byte;
    n_sent = (n_used == 0) ? 1 : n_used;
    crc    = 8'h00;
    for (int k = 0; k < n_sent; k++) begin
      if (k == 0)                 body[k] = cmd;
      else if (kind == BodyAscii) body[k] = AsciiZero + cfsr_byte_t'($urandom_range(9));
      else if (kind == BodyStart) body[k] = StartByte;
      else                        body[k] = cfsr_byte_t'($urandom);
      if (k < n_used) crc = crc8_step(crc, body[k]);
    end
    crc = crc ^ CrcXorOut;
    if (bad_crc) crc = crc ^ cfsr_byte_t'($urandom_range(255, 1));
    queue_byte(StartByte);
    queue_byte(crc);
    queue_byte(len_byte);
    for (int k = 0; k < n_sent; k++) queue_byte(body[k]);
  endtask

  task automatic queue_random_traffic(input int unsigned upto);
    int unsigned pick;
    int unsigned lsel;
    cfsr_byte_t  cmd;
    cfsr_byte_t  len;
    body_kind_e  kind;
    while (bytes_queued < upto) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        cmd  = ($urandom_range(99) < 60) ? status_code : cfsr_byte_t'($urandom);
        lsel = $urandom_range(99);
        if (lsel < 55)      len = cfsr_byte_t'($urandom_range(9));
        else if (lsel < 85) len = cfsr_byte_t'($urandom_range(31, 10));
        else                len = cfsr_byte_t'($urandom_range(255, 32));
        kind = (len <= BinaryMinLen && $urandom_range(99) < 70) ? BodyAscii : BodyRandom;
        queue_frame(cmd, len, kind, $urandom_range(99) < 15);
      end else if (pick < 93) begin
        repeat ($urandom_range(4, 1)) queue_byte(cfsr_byte_t'($urandom));
      end else begin
        // cut a frame short; the next bytes finish it
        queue_byte(StartByte);
        queue_byte(cfsr_byte_t'($urandom));
        queue_byte(cfsr_byte_t'($urandom_range(31, 10)));
        repeat ($urandom_range(5, 1)) queue_byte(cfsr_byte_t'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_valid_i || frame_result_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_status_code(input cfsr_byte_t code);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    status_code  = code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    cfsr_byte_t code;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_status_code(8'h00);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_frame(8'h00, 8'd0, BodyAscii, 1'b0);
    queue_frame(8'h00, 8'd9, BodyAscii, 1'b0);
    queue_frame(8'h00, 8'd10, BodyStart, 1'b0);
    queue_frame(8'h11, 8'd1, BodyRandom, 1'b1);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       code = 8'hFF;
        1:       code = 8'h00;
        4:       code = StartByte;
        default: code = cfsr_byte_t'($urandom);
      endcase
      write_status_code(code);
      case (ph)
        0, 5:           idle_pct <= 0;
        NumPhases - 1:  idle_pct <= 0;
        default:        idle_pct <= $urandom_range(40, 5);
      endcase
      queue_random_traffic(bytes_queued + PhaseBytes);
      if (ph == 2) begin
        // hold the receiver off while the sender keeps offering
        @(posedge clk_i);
        holdoff_go <= 1'b1;
        @(posedge clk_i);
        holdoff_go <= 1'b0;
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
